// ===== hw/rtl/ngks_pkg.sv =====
package ngks_pkg;

    // Table geometry and field widths.
    localparam int ENTRIES_DEFAULT = 32;
    localparam int IDX_W           = 5;
    localparam int KEY_W           = 16;
    localparam int CODE_W          = 16;
    localparam int SPEED_W         = 24;
    localparam int RPM_W           = 20;
    localparam int COUNT_W         = 6;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;

    // Request type codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ENTRY_COUNT   = 3'd0;
    localparam logic [2:0] REG_MAX_RPM       = 3'd1;
    localparam logic [2:0] REG_NEUTRAL_ENTRY = 3'd2;
    localparam logic [2:0] REG_TOP_ENTRY     = 3'd3;
    localparam logic [2:0] REG_LOWEST_ENTRY  = 3'd4;

    // Register reset values.
    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 6'd1;
    localparam logic [KEY_W-1:0]   MAX_RPM_RESET     = 16'd4000;
    localparam logic [IDX_W-1:0]   ENTRY_REG_RESET   = 5'd0;

    // Input beat.
    typedef struct packed {
        logic                      req_type;
        logic [IDX_W-1:0]          entry_index;
        logic [KEY_W-1:0]          entry_key;
        logic [CODE_W-1:0]         entry_code;
        logic signed [SPEED_W-1:0] speed_request;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic [IDX_W-1:0]  gear_index;
        logic [KEY_W-1:0]  gear_key;
        logic [CODE_W-1:0] gear_code;
    } result_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic [KEY_W-1:0]   max_rpm;
        logic [IDX_W-1:0]   neutral_entry;
        logic [IDX_W-1:0]   top_entry;
        logic [IDX_W-1:0]   lowest_entry;
    } cfg_t;

    // Source of the key memory read addresses.
    typedef enum logic [1:0] {
        RD_LOW,
        RD_INIT,
        RD_STEP,
        RD_SEL
    } rd_src_t;

    // Source of the selected entry register.
    typedef enum logic [2:0] {
        SEL_HOLD,
        SEL_NEUTRAL,
        SEL_TOP,
        SEL_LOW,
        SEL_SCAN,
        SEL_ZERO
    } sel_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     write_en;
        logic     load_speed;
        logic     init_scan;
        logic     step_scan;
        rd_src_t  rd_src;
        sel_src_t sel_src;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_neutral;
        logic is_top;
        logic low_hit;
        logic n_is_one;
        logic mid_hit;
        logic j_is_one;
    } stat_t;

endpackage

// ===== hw/rtl/nearest_key_gear_select.sv =====
// Gear selector: a load beat writes one key/code pair of the table, with no
// result. A query beat returns one result beat, on result for exactly one cycle
// with done high; it cannot be held off, so the receiver must take it in that
// cycle. After a query, busy covers the classify and fetch states when the speed
// is zero, negative or at or above max_rpm, adds the lowest-entry check when the
// lowest or only entry is chosen, the downward scan otherwise, which compares
// one neighbor midpoint per cycle from the key memories; done is high in the
// first cycle in which busy is low. A new beat may be started in the cycle the
// result is shown. The user must write registers over the APB port only while
// the block is idle; the block itself does not enforce this.
module nearest_key_gear_select #(
    parameter int ENTRIES = ngks_pkg::ENTRIES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  ngks_pkg::req_t                      req,
    output logic                                busy,
    output logic                                done,
    output ngks_pkg::result_t                   result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ngks_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ngks_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ngks_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    ngks_pkg::cfg_t  cfg_reg;
    ngks_pkg::cfg_t  cfg_next;
    ngks_pkg::cmd_t  cmd;
    ngks_pkg::stat_t stat;
    logic [2:0]      reg_idx;
    logic            cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                ngks_pkg::REG_ENTRY_COUNT:
                    cfg_next.entry_count = pwdata[ngks_pkg::COUNT_W-1:0];
                ngks_pkg::REG_MAX_RPM:
                    cfg_next.max_rpm = pwdata[ngks_pkg::KEY_W-1:0];
                ngks_pkg::REG_NEUTRAL_ENTRY:
                    cfg_next.neutral_entry = pwdata[ngks_pkg::IDX_W-1:0];
                ngks_pkg::REG_TOP_ENTRY:
                    cfg_next.top_entry = pwdata[ngks_pkg::IDX_W-1:0];
                ngks_pkg::REG_LOWEST_ENTRY:
                    cfg_next.lowest_entry = pwdata[ngks_pkg::IDX_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_count   <= ngks_pkg::ENTRY_COUNT_RESET;
            cfg_reg.max_rpm       <= ngks_pkg::MAX_RPM_RESET;
            cfg_reg.neutral_entry <= ngks_pkg::ENTRY_REG_RESET;
            cfg_reg.top_entry     <= ngks_pkg::ENTRY_REG_RESET;
            cfg_reg.lowest_entry  <= ngks_pkg::ENTRY_REG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register reads.
    always_comb
    begin
        case (reg_idx)
            ngks_pkg::REG_ENTRY_COUNT:
                prdata = ngks_pkg::APB_DATA_W'(cfg_reg.entry_count);
            ngks_pkg::REG_MAX_RPM:
                prdata = ngks_pkg::APB_DATA_W'(cfg_reg.max_rpm);
            ngks_pkg::REG_NEUTRAL_ENTRY:
                prdata = ngks_pkg::APB_DATA_W'(cfg_reg.neutral_entry);
            ngks_pkg::REG_TOP_ENTRY:
                prdata = ngks_pkg::APB_DATA_W'(cfg_reg.top_entry);
            ngks_pkg::REG_LOWEST_ENTRY:
                prdata = ngks_pkg::APB_DATA_W'(cfg_reg.lowest_entry);
            default:
                prdata = '0;
        endcase
    end

    ngks_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .is_query (req.req_type == ngks_pkg::REQ_QUERY),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    ngks_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk    (clk),
        .cfg    (cfg_reg),
        .req    (req),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

    // A result beat only follows a busy cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a preceding query");

    // An accepted query keeps the block busy in the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type == ngks_pkg::REQ_QUERY)) |=> busy)
        else $error("query accepted but block not busy");

    // A load beat never produces a result beat.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type == ngks_pkg::REQ_LOAD)) |=> !done)
        else $error("result beat after a load");

    // The selected entry always lies inside the table.
    a_index_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.gear_index) < ENTRIES))
        else $error("selected entry outside the table");

endmodule

// ===== hw/rtl/ngks_ram.sv =====
module ngks_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ngks_datapath.sv =====
module ngks_datapath #(
    parameter int ENTRIES = ngks_pkg::ENTRIES_DEFAULT
) (
    input  logic             clk,
    input  ngks_pkg::cfg_t   cfg,
    input  ngks_pkg::req_t   req,
    input  ngks_pkg::cmd_t   cmd,
    output ngks_pkg::stat_t  stat,
    output ngks_pkg::result_t result
);

    localparam int AW    = $clog2(ENTRIES);
    localparam int IDX_N = 1 << ngks_pkg::IDX_W;
    localparam int N_CAP = (ENTRIES < IDX_N) ? ENTRIES : IDX_N;

    typedef logic [IDX_N-1:0][ngks_pkg::IDX_W-1:0] wrap_tab_t;

    // Entry register values folded into the table, worked out at elaboration.
    function automatic wrap_tab_t build_wrap_tab();
        wrap_tab_t tab;
        for (int i = 0; i < IDX_N; i++)
        begin
            tab[i] = ngks_pkg::IDX_W'(i % ENTRIES);
        end
        return tab;
    endfunction

    localparam wrap_tab_t WRAP_TAB = build_wrap_tab();

    logic signed [ngks_pkg::SPEED_W-1:0] speed_reg;
    logic signed [ngks_pkg::SPEED_W-1:0] speed_next;
    logic [ngks_pkg::IDX_W-1:0]          sel_reg;
    logic [ngks_pkg::IDX_W-1:0]          sel_next;
    logic [ngks_pkg::IDX_W-1:0]          j_reg;
    logic [ngks_pkg::IDX_W-1:0]          j_next;

    logic [ngks_pkg::IDX_W-1:0]   neutral_idx;
    logic [ngks_pkg::IDX_W-1:0]   top_idx;
    logic [ngks_pkg::IDX_W-1:0]   low_idx;
    logic [ngks_pkg::COUNT_W-1:0] count_nz;
    logic [ngks_pkg::COUNT_W-1:0] n_eff;
    logic [ngks_pkg::IDX_W-1:0]   n_minus1;
    logic [ngks_pkg::IDX_W-1:0]   addr_a_idx;
    logic [ngks_pkg::IDX_W-1:0]   addr_b_idx;
    logic [ngks_pkg::SPEED_W-1:0] speed_u;
    logic [ngks_pkg::SPEED_W-1:0] rounded_sum;
    logic [ngks_pkg::RPM_W-1:0]   rounded;
    logic [ngks_pkg::KEY_W:0]     pair_sum;
    logic [ngks_pkg::KEY_W-1:0]   mid;
    logic [ngks_pkg::KEY_W-1:0]   key_a;
    logic [ngks_pkg::KEY_W-1:0]   key_b;
    logic [ngks_pkg::CODE_W-1:0]  code_q;
    logic                         wr_en;

    // Folded entry registers and the effective entry count.
    always_comb
    begin
        neutral_idx = WRAP_TAB[cfg.neutral_entry];
        top_idx     = WRAP_TAB[cfg.top_entry];
        low_idx     = WRAP_TAB[cfg.lowest_entry];
        count_nz    = (cfg.entry_count == '0) ? ngks_pkg::COUNT_W'(1) : cfg.entry_count;
        n_eff       = (32'(count_nz) > N_CAP) ? ngks_pkg::COUNT_W'(N_CAP) : count_nz;
        n_minus1    = ngks_pkg::IDX_W'(n_eff - ngks_pkg::COUNT_W'(1));
    end

    // Speed classification, rounding to whole rpm and the midpoint compare.
    always_comb
    begin
        speed_u     = ngks_pkg::SPEED_W'(speed_reg);
        rounded_sum = speed_u + ngks_pkg::SPEED_W'(8);
        rounded     = rounded_sum[ngks_pkg::SPEED_W-1:4];
        pair_sum    = {1'b0, key_a} + {1'b0, key_b};
        mid         = pair_sum[ngks_pkg::KEY_W:1];

        stat.is_neutral = (speed_u == '0) || speed_u[ngks_pkg::SPEED_W-1];
        stat.is_top     = speed_u >= {4'b0000, cfg.max_rpm, 4'b0000};
        stat.low_hit    = speed_u <= {4'b0000, key_a, 4'b0000};
        stat.n_is_one   = (n_eff == ngks_pkg::COUNT_W'(1));
        stat.mid_hit    = {4'b0000, mid} <= rounded;
        stat.j_is_one   = (j_reg == ngks_pkg::IDX_W'(1));
    end

    // Read address selection for the two key memories.
    always_comb
    begin
        case (cmd.rd_src)
            ngks_pkg::RD_LOW:
            begin
                addr_a_idx = low_idx;
                addr_b_idx = low_idx;
            end
            ngks_pkg::RD_INIT:
            begin
                addr_a_idx = n_minus1 - ngks_pkg::IDX_W'(1);
                addr_b_idx = n_minus1;
            end
            ngks_pkg::RD_STEP:
            begin
                addr_a_idx = j_reg - ngks_pkg::IDX_W'(2);
                addr_b_idx = j_reg - ngks_pkg::IDX_W'(1);
            end
            default:
            begin
                addr_a_idx = sel_reg;
                addr_b_idx = sel_reg;
            end
        endcase
    end

    // Next values of the speed, scan index and selection registers.
    always_comb
    begin
        speed_next = cmd.load_speed ? req.speed_request : speed_reg;

        if (cmd.init_scan)
        begin
            j_next = n_minus1;
        end
        else if (cmd.step_scan)
        begin
            j_next = j_reg - ngks_pkg::IDX_W'(1);
        end
        else
        begin
            j_next = j_reg;
        end

        case (cmd.sel_src)
            ngks_pkg::SEL_NEUTRAL: sel_next = neutral_idx;
            ngks_pkg::SEL_TOP:     sel_next = top_idx;
            ngks_pkg::SEL_LOW:     sel_next = low_idx;
            ngks_pkg::SEL_SCAN:    sel_next = j_reg;
            ngks_pkg::SEL_ZERO:    sel_next = '0;
            default:               sel_next = sel_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        speed_reg <= speed_next;
        j_reg     <= j_next;
        sel_reg   <= sel_next;
    end

    // Loads beyond the table are dropped.
    assign wr_en = cmd.write_en && (32'(req.entry_index) < ENTRIES);

    // Two copies of the key table give both keys of a neighbor pair per cycle.
    ngks_ram #(
        .WIDTH (ngks_pkg::KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(req.entry_index)),
        .wdata (req.entry_key),
        .raddr (AW'(addr_a_idx)),
        .rdata (key_a)
    );

    ngks_ram #(
        .WIDTH (ngks_pkg::KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(req.entry_index)),
        .wdata (req.entry_key),
        .raddr (AW'(addr_b_idx)),
        .rdata (key_b)
    );

    ngks_ram #(
        .WIDTH (ngks_pkg::CODE_W),
        .DEPTH (ENTRIES)
    ) u_code (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(req.entry_index)),
        .wdata (req.entry_code),
        .raddr (AW'(sel_reg)),
        .rdata (code_q)
    );

    // The result is read from the memories in the cycle after the fetch.
    always_comb
    begin
        result.gear_index = sel_reg;
        result.gear_key   = key_a;
        result.gear_code  = code_q;
    end

endmodule

// ===== hw/rtl/ngks_ctrl.sv =====
module ngks_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            is_query,
    input  ngks_pkg::stat_t stat,
    output ngks_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_LOWCHK,
        ST_SCAN,
        ST_FETCH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // Loads write; a query: classify, check lowest entry, scan down, fetch.
    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        cmd.write_en   = 1'b0;
        cmd.load_speed = 1'b0;
        cmd.init_scan  = 1'b0;
        cmd.step_scan  = 1'b0;
        cmd.rd_src     = ngks_pkg::RD_SEL;
        cmd.sel_src    = ngks_pkg::SEL_HOLD;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (is_query)
                    begin
                        cmd.load_speed = 1'b1;
                        state_next     = ST_CLASS;
                    end
                    else
                    begin
                        cmd.write_en = 1'b1;
                    end
                end
            end
            ST_CLASS:
            begin
                if (stat.is_neutral)
                begin
                    cmd.sel_src = ngks_pkg::SEL_NEUTRAL;
                    state_next  = ST_FETCH;
                end
                else if (stat.is_top)
                begin
                    cmd.sel_src = ngks_pkg::SEL_TOP;
                    state_next  = ST_FETCH;
                end
                else
                begin
                    cmd.rd_src = ngks_pkg::RD_LOW;
                    state_next = ST_LOWCHK;
                end
            end
            ST_LOWCHK:
            begin
                if (stat.low_hit)
                begin
                    cmd.sel_src = ngks_pkg::SEL_LOW;
                    state_next  = ST_FETCH;
                end
                else if (stat.n_is_one)
                begin
                    cmd.sel_src = ngks_pkg::SEL_ZERO;
                    state_next  = ST_FETCH;
                end
                else
                begin
                    cmd.init_scan = 1'b1;
                    cmd.rd_src    = ngks_pkg::RD_INIT;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.mid_hit)
                begin
                    cmd.sel_src = ngks_pkg::SEL_SCAN;
                    state_next  = ST_FETCH;
                end
                else if (stat.j_is_one)
                begin
                    cmd.sel_src = ngks_pkg::SEL_ZERO;
                    state_next  = ST_FETCH;
                end
                else
                begin
                    cmd.step_scan = 1'b1;
                    cmd.rd_src    = ngks_pkg::RD_STEP;
                end
            end
            ST_FETCH:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule
